>>> src/twdf_pkg.sv
// Package for the two-window duplicate filter: beat types, chain token and cell control.
// Used by twdf_cell and two_window_duplicate_filter_top; depends on nothing else.
`timescale 1ns / 1ps

package twdf_pkg;

	localparam int WINDOW_ENTRIES_DEF = 64;

	typedef struct packed {
		logic [63:0] id_high;
		logic [63:0] id_low;
	} id_t;

	typedef struct packed {
		logic is_duplicate;
		logic windows_rotated;
	} result_t;

	// Lookup token that walks the cell row, one cell per cycle.
	typedef struct packed {
		logic valid;
		logic hit;
		id_t  id;
	} tok_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic wr_en;
		logic wr_b;
		logic clr_a;
		logic clr_b;
		id_t  id;
	} cell_ctl_t;

endpackage

>>> src/two_window_duplicate_filter_top.sv
// Top level of the two-window duplicate filter: launch, cell row and insert control.
// Depends on twdf_pkg and twdf_cell.
//
//   channel   handshake            payload
//   input     start, busy          id     (id_high, id_low)
//   result    done                 result (is_duplicate, windows_rotated)
//
// An identifier's lookup token crosses the row of WINDOW_ENTRIES cells one cell a cycle;
// its result is registered, together with done, when the token leaves the last cell.
// busy is high from the accepting edge until the edge that raises done, so the next
// beat can be taken at the edge that ends the result cycle.
// Reset empties both windows at once; no clearing pass is needed.
// done is high for exactly one cycle and cannot be stalled.
`timescale 1ns / 1ps

module two_window_duplicate_filter_top #(
	parameter int WINDOW_ENTRIES = twdf_pkg::WINDOW_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  twdf_pkg::id_t     id,
	output logic              done,
	output twdf_pkg::result_t result
);
	import twdf_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_ENTRIES);

	tok_t             tok_c [WINDOW_ENTRIES+1];
	cell_ctl_t        ctl;
	logic [IDX_W-1:0] fill_q;
	logic             cur_b_q;
	logic             busy_q;
	logic             done_q;
	result_t          result_q;
	logic             accept;
	logic             finish;
	logic             insert;
	logic             full;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// launch; an all-zero identifier is looked up and stored as low word 1
	always_comb begin
		tok_c[0].valid = accept;
		tok_c[0].hit   = 1'b0;
		tok_c[0].id    = id;
		if (id.id_high == 64'd0 && id.id_low == 64'd0)
			tok_c[0].id.id_low = 64'd1;
	end

	for (genvar i = 0; i < WINDOW_ENTRIES; i++) begin : g_cell
		twdf_cell #(
			.IDX_W  (IDX_W),
			.MY_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_c[i]),
			.ctl     (ctl),
			.wr_idx  (fill_q),
			.tok_out (tok_c[i+1])
		);
	end

	assign finish = tok_c[WINDOW_ENTRIES].valid;
	assign insert = finish && !tok_c[WINDOW_ENTRIES].hit;
	assign full   = (fill_q == IDX_W'(WINDOW_ENTRIES - 1));

	always_comb begin
		ctl.wr_en = insert;
		ctl.wr_b  = cur_b_q;
		ctl.clr_a = insert && full && cur_b_q;
		ctl.clr_b = insert && full && !cur_b_q;
		ctl.id    = tok_c[WINDOW_ENTRIES].id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			cur_b_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			if (accept)
				busy_q <= 1'b1;
			else if (finish)
				busy_q <= 1'b0;
			if (insert) begin
				if (full) begin
					fill_q  <= '0;
					cur_b_q <= !cur_b_q;
				end else begin
					fill_q <= fill_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.is_duplicate    <= tok_c[WINDOW_ENTRIES].hit;
			result_q.windows_rotated <= insert && full;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an item is still in the row");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_rot_not_dup: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.windows_rotated |-> !result.is_duplicate)
		else $error("rotation reported on a duplicate");

	a_rot_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.windows_rotated |-> fill_q == '0)
		else $error("fill count not restarted after rotation");

endmodule

>>> src/twdf_cell.sv
// One slot of each window plus one stage of the lookup chain.
// Depends on twdf_pkg.
`timescale 1ns / 1ps

module twdf_cell #(
	parameter int IDX_W  = 6,
	parameter int MY_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  twdf_pkg::tok_t    tok_in,
	input  twdf_pkg::cell_ctl_t ctl,
	input  logic [IDX_W-1:0]  wr_idx,
	output twdf_pkg::tok_t    tok_out
);
	import twdf_pkg::*;

	tok_t tok_q;
	id_t  ent_a_q;
	id_t  ent_b_q;
	logic val_a_q;
	logic val_b_q;
	logic sel;
	logic match;

	assign sel   = ctl.wr_en && (wr_idx == IDX_W'(MY_IDX));
	assign match = (val_a_q && ent_a_q == tok_q.id) || (val_b_q && ent_b_q == tok_q.id);

	always_comb begin
		tok_out     = tok_q;
		tok_out.hit = tok_q.hit | match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			val_a_q <= 1'b0;
			val_b_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			// drop the window that becomes current, then mark the new slot
			if (ctl.clr_a)
				val_a_q <= 1'b0;
			if (ctl.clr_b)
				val_b_q <= 1'b0;
			if (sel && !ctl.wr_b)
				val_a_q <= 1'b1;
			if (sel && ctl.wr_b)
				val_b_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && !ctl.wr_b)
			ent_a_q <= ctl.id;
		if (sel && ctl.wr_b)
			ent_b_q <= ctl.id;
	end

endmodule
